### rtl/core/rhh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared constants, codes and pipeline payload types for the RGB/HSV/HSL
// color space converter.
// ----------------------------------------------------------------------------
package rhh_pkg;

  // channel and hue number formats
  localparam int CH_BITS = 12;
  localparam int HUE_BITS = 13;
  localparam int FRAC_BITS = 10;
  localparam logic [CH_BITS-1:0] FULL_SCALE = 12'd4095;
  localparam logic [HUE_BITS-1:0] HUE_FULL = 13'd5760;
  localparam logic [HUE_BITS-1:0] HUE_SECTOR = 13'd960;

  // pipelined divider: quotient bits resolved per stage and stage count
  localparam int NUM_BITS = 2 * CH_BITS;
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = CH_BITS / DIV_STEPS;

  // operation codes
  typedef enum logic [1:0] {
    OP_RGB2HSV = 2'd0,
    OP_RGB2HSL = 2'd1,
    OP_HSV2RGB = 2'd2,
    OP_HSL2RGB = 2'd3
  } op_t;

  // max channel codes
  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_ch_t;

  // sideband from input stage through the first divider
  typedef struct packed {
    op_t                 op;
    logic [CH_BITS-1:0]  alpha;
    logic                undef;
    max_ch_t             ch;
    logic                neg;
    logic [2:0]          sector;
    logic [FRAC_BITS-1:0] frac;
    logic [HUE_BITS-1:0] tval;
  } side_t;

  // sideband through the second divider
  typedef struct packed {
    op_t                 op;
    logic [CH_BITS-1:0]  alpha;
    logic                undef;
    logic [2:0]          sector;
    logic [HUE_BITS-1:0] f1;
    logic [CH_BITS-1:0]  f2;
    logic [CH_BITS-1:0]  f3;
  } mid_t;

endpackage

### rtl/core/rhh_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_stream_if
// Valid/ready channels carrying one pixel beat in and one result beat out.
// ----------------------------------------------------------------------------
interface rhh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [12:0] in_first;
  logic [11:0] in_second;
  logic [11:0] in_third;
  logic [11:0] in_alpha;

  modport source (output valid, operation, in_first, in_second, in_third, in_alpha,
                  input ready);
  modport sink (input valid, operation, in_first, in_second, in_third, in_alpha,
                output ready);
endinterface

interface rhh_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] out_first;
  logic [11:0] out_second;
  logic [11:0] out_third;
  logic [11:0] out_alpha;
  logic        hue_undefined;

  modport source (output valid, out_first, out_second, out_third, out_alpha,
                  hue_undefined, input ready);
  modport sink (input valid, out_first, out_second, out_third, out_alpha,
                hue_undefined, output ready);
endinterface

### rtl/core/rhh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_div
// Pipelined restoring divider: a 24-bit dividend over a 12-bit divisor with a
// quotient known to fit in 12 bits, two quotient bits per stage.
// ----------------------------------------------------------------------------
module rhh_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rhh_pkg::NUM_BITS-1:0] num,
  input  logic [rhh_pkg::CH_BITS-1:0]  den,
  output logic [rhh_pkg::CH_BITS-1:0]  quo
);
  import rhh_pkg::*;

  logic [CH_BITS-1:0] rem_q [DIV_STAGES];
  logic [CH_BITS-1:0] low_q [DIV_STAGES];
  logic [CH_BITS-1:0] den_q [DIV_STAGES];
  logic [CH_BITS-1:0] quo_q [DIV_STAGES];

  genvar g;
  generate
    for (g = 0; g < DIV_STAGES; g++) begin : g_stage
      logic [CH_BITS-1:0] rem_in, low_in, den_in, quo_in;
      logic [CH_BITS-1:0] rem_next, low_next, quo_next;

      // stage inputs
      if (g == 0) begin : g_first
        assign rem_in = num[NUM_BITS-1:CH_BITS];
        assign low_in = num[CH_BITS-1:0];
        assign den_in = den;
        assign quo_in = '0;
      end else begin : g_rest
        assign rem_in = rem_q[g-1];
        assign low_in = low_q[g-1];
        assign den_in = den_q[g-1];
        assign quo_in = quo_q[g-1];
      end

      // shift in a dividend bit, subtract when the divisor fits
      always_comb begin : p_steps
        logic [CH_BITS:0] trial;
        rem_next = rem_in;
        low_next = low_in;
        quo_next = quo_in;
        for (int k = 0; k < DIV_STEPS; k++) begin
          trial = {rem_next, low_next[CH_BITS-1]};
          low_next = {low_next[CH_BITS-2:0], 1'b0};
          if (trial >= {1'b0, den_in}) begin
            trial = trial - {1'b0, den_in};
            quo_next = {quo_next[CH_BITS-2:0], 1'b1};
          end else begin
            quo_next = {quo_next[CH_BITS-2:0], 1'b0};
          end
          rem_next = trial[CH_BITS-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[g] <= rem_next;
          low_q[g] <= low_next;
          den_q[g] <= den_in;
          quo_q[g] <= quo_next;
        end
      end
    end
  endgenerate

  assign quo = quo_q[DIV_STAGES-1];

endmodule

### rtl/core/rgb_hsv_hsl_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_hsv_hsl_converter_core
// Pixel converter between RGB and HSV or HSL, with rounding dividers.
// ----------------------------------------------------------------------------
// Usage:
//   pixel carries one beat per pixel: operation, three 12/13-bit components
//   and alpha. result returns exactly one beat per pixel, in order, with
//   alpha copied through and hue_undefined set for gray pixels on the
//   forward operations.
//   From pixel beat to result valid a pixel passes the input stage, the
//   multiply stage, a 6-stage hue/saturation divider, a merge stage, a
//   6-stage divider for the inverse sector ramp, and the output register.
//   Throughput is one pixel per clock while result.ready keeps up; every
//   pipeline register advances on one shared enable.
//   When the receiver holds result.ready low with a result waiting, the
//   whole pipeline freezes and pixel.ready drops in the same cycle; nothing
//   is lost or repeated. pixel.ready is high whenever the output register is
//   empty or being drained.
//   Synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module rgb_hsv_hsl_converter_core (
  input  logic       clk,
  input  logic       rst,
  rhh_in_if.sink     pixel,
  rhh_out_if.source  result
);
  import rhh_pkg::*;

  logic en;

  // global advance: output empty or being taken
  assign en = ~result.valid | result.ready;
  assign pixel.ready = en;

  // --------------------------------------------------------------------------
  // input stage combinational logic
  // --------------------------------------------------------------------------
  logic                 is_fwd, is_hsl;
  logic [CH_BITS-1:0]   r_c, g_c, b_c, mx, mn, c0, p_v, q_v, diff, sden;
  logic [CH_BITS-1:0]   span, mul_a;
  max_ch_t              ch;
  logic [HUE_BITS-1:0]  sum, sum_half, hue_w, hue_rem, two_l;
  logic [2:0]           sector;
  logic [FRAC_BITS-1:0] frac;

  assign is_fwd = ~pixel.operation[1];
  assign is_hsl = pixel.operation[0];

  // forward: max, min, chroma and hue difference
  always_comb begin
    r_c = (pixel.in_first > {1'b0, FULL_SCALE}) ? FULL_SCALE
                                                 : pixel.in_first[CH_BITS-1:0];
    g_c = pixel.in_second;
    b_c = pixel.in_third;
    if (r_c > g_c) begin
      ch = MAX_RED;
      mx = r_c;
    end else begin
      ch = MAX_GREEN;
      mx = g_c;
    end
    if (b_c > mx) begin
      ch = MAX_BLUE;
      mx = b_c;
    end
    mn = (r_c < g_c) ? r_c : g_c;
    if (b_c < mn) mn = b_c;
    c0 = mx - mn;
    case (ch)
      MAX_RED: begin
        p_v = g_c;
        q_v = b_c;
      end
      MAX_GREEN: begin
        p_v = b_c;
        q_v = r_c;
      end
      default: begin
        p_v = r_c;
        q_v = g_c;
      end
    endcase
    diff = (p_v >= q_v) ? (p_v - q_v) : (q_v - p_v);
    sum = {1'b0, mx} + {1'b0, mn};
    sum_half = (sum + 13'd1) >> 1;
    sden = (sum <= {1'b0, FULL_SCALE}) ? sum[CH_BITS-1:0]
                                       : CH_BITS'({FULL_SCALE, 1'b0} - sum);
  end

  // inverse: hue wrap, sector, ramp position and chroma multiplicand
  always_comb begin
    hue_w = (pixel.in_first >= HUE_FULL) ? (pixel.in_first - HUE_FULL)
                                         : pixel.in_first;
    sector = 3'd0;
    hue_rem = hue_w;
    for (int k = 1; k < 6; k++) begin
      if (hue_w >= HUE_BITS'(k * 960)) begin
        sector = 3'(k);
        hue_rem = hue_w - HUE_BITS'(k * 960);
      end
    end
    frac = sector[0] ? FRAC_BITS'(HUE_SECTOR - hue_rem) : hue_rem[FRAC_BITS-1:0];
    two_l = {pixel.in_third, 1'b0};
    span = (two_l <= {1'b0, FULL_SCALE}) ? two_l[CH_BITS-1:0]
                                         : CH_BITS'({FULL_SCALE, 1'b0} - two_l);
    mul_a = is_hsl ? span : pixel.in_third;
  end

  // --------------------------------------------------------------------------
  // stage 0 registers
  // --------------------------------------------------------------------------
  logic               v0;
  logic [CH_BITS-1:0] s0_x, s0_y, s0_dena, s0_c, s0_sden;
  side_t              s0_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x    <= is_fwd ? diff : mul_a;
      s0_y    <= is_fwd ? HUE_SECTOR[CH_BITS-1:0] : pixel.in_second;
      s0_dena <= is_fwd ? c0 : FULL_SCALE;
      s0_c    <= c0;
      s0_sden <= is_hsl ? sden : mx;
      s0_side.op     <= op_t'(pixel.operation);
      s0_side.alpha  <= pixel.in_alpha;
      s0_side.undef  <= is_fwd & (c0 == '0);
      s0_side.ch     <= ch;
      s0_side.neg    <= (p_v < q_v);
      s0_side.sector <= sector;
      s0_side.frac   <= frac;
      if (is_fwd) begin
        s0_side.tval <= {1'b0, (is_hsl ? sum_half[CH_BITS-1:0] : mx)};
      end else begin
        s0_side.tval <= is_hsl ? two_l : {1'b0, pixel.in_third};
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: dividends with the rounding half added
  // --------------------------------------------------------------------------
  logic                v1;
  logic [NUM_BITS-1:0] s1_numa, s1_numb;
  logic [CH_BITS-1:0]  s1_dena, s1_denb;
  side_t               s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_numa <= (NUM_BITS'(s0_x) * NUM_BITS'(s0_y)) + NUM_BITS'(s0_dena >> 1);
      s1_numb <= ({s0_c, {CH_BITS{1'b0}}} - NUM_BITS'(s0_c)) + NUM_BITS'(s0_sden >> 1);
      s1_dena <= s0_dena;
      s1_denb <= s0_sden;
      s1_side <= s0_side;
    end
  end

  // --------------------------------------------------------------------------
  // first divider pair: hue and saturation, or inverse chroma
  // --------------------------------------------------------------------------
  logic [CH_BITS-1:0] qa, qb;
  logic               va [DIV_STAGES];
  side_t              sa [DIV_STAGES];

  rhh_div u_div_a (.clk(clk), .en(en), .num(s1_numa), .den(s1_dena), .quo(qa));
  rhh_div u_div_b (.clk(clk), .en(en), .num(s1_numb), .den(s1_denb), .quo(qb));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) va[i] <= 1'b0;
    end else if (en) begin
      va[0] <= v1;
      for (int i = 1; i < DIV_STAGES; i++) va[i] <= va[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa[0] <= s1_side;
      for (int i = 1; i < DIV_STAGES; i++) sa[i] <= sa[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // merge stage: final hue, or offset and ramp dividend
  // --------------------------------------------------------------------------
  side_t               sl;
  logic [13:0]         base;
  logic signed [14:0]  hs;
  logic [HUE_BITS-1:0] hue;
  logic [13:0]         m_hsl;
  logic [CH_BITS-1:0]  m_val;
  logic [NUM_BITS-1:0] numx;

  assign sl = sa[DIV_STAGES-1];

  always_comb begin
    case (sl.ch)
      MAX_RED:   base = 14'd0;
      MAX_GREEN: base = 14'd1920;
      default:   base = 14'd3840;
    endcase
    if (sl.neg) begin
      hs = $signed({1'b0, base}) - $signed({3'b0, qa});
    end else begin
      hs = $signed({1'b0, base}) + $signed({3'b0, qa});
    end
    if (hs < 0) begin
      hs = hs + 15'sd5760;
    end else if (hs >= 15'sd5760) begin
      hs = hs - 15'sd5760;
    end
    hue = hs[HUE_BITS-1:0];
    m_hsl = ({1'b0, sl.tval} - {2'b0, qa} + 14'd1) >> 1;
    m_val = sl.op[0] ? m_hsl[CH_BITS-1:0] : (sl.tval[CH_BITS-1:0] - qa);
    numx = (NUM_BITS'(qa) * NUM_BITS'(sl.frac)) + NUM_BITS'(HUE_SECTOR >> 1);
  end

  logic                vm;
  logic [NUM_BITS-1:0] m_numx;
  mid_t                m_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= va[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_numx        <= numx;
      m_side.op     <= sl.op;
      m_side.alpha  <= sl.alpha;
      m_side.undef  <= sl.undef;
      m_side.sector <= sl.sector;
      if (~sl.op[1]) begin
        m_side.f1 <= sl.undef ? '0 : hue;
        m_side.f2 <= sl.undef ? '0 : qb;
        m_side.f3 <= sl.tval[CH_BITS-1:0];
      end else begin
        m_side.f1 <= '0;
        m_side.f2 <= qa;
        m_side.f3 <= m_val;
      end
    end
  end

  // --------------------------------------------------------------------------
  // second divider: inverse ramp value
  // --------------------------------------------------------------------------
  logic [CH_BITS-1:0] qx;
  logic               vb [DIV_STAGES];
  mid_t               mb [DIV_STAGES];

  rhh_div u_div_x (.clk(clk), .en(en), .num(m_numx),
                   .den(HUE_SECTOR[CH_BITS-1:0]), .quo(qx));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) vb[i] <= 1'b0;
    end else if (en) begin
      vb[0] <= vm;
      for (int i = 1; i < DIV_STAGES; i++) vb[i] <= vb[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mb[0] <= m_side;
      for (int i = 1; i < DIV_STAGES; i++) mb[i] <= mb[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // output composition: sector permutation plus offset, saturated
  // --------------------------------------------------------------------------
  mid_t               ml;
  logic [CH_BITS-1:0] pr, pg, pb, cc;
  logic [CH_BITS:0]   sr, sg, sb;

  assign ml = mb[DIV_STAGES-1];
  assign cc = ml.f2;

  always_comb begin
    case (ml.sector)
      3'd0: begin
        pr = cc; pg = qx; pb = '0;
      end
      3'd1: begin
        pr = qx; pg = cc; pb = '0;
      end
      3'd2: begin
        pr = '0; pg = cc; pb = qx;
      end
      3'd3: begin
        pr = '0; pg = qx; pb = cc;
      end
      3'd4: begin
        pr = qx; pg = '0; pb = cc;
      end
      default: begin
        pr = cc; pg = '0; pb = qx;
      end
    endcase
    sr = {1'b0, pr} + {1'b0, ml.f3};
    sg = {1'b0, pg} + {1'b0, ml.f3};
    sb = {1'b0, pb} + {1'b0, ml.f3};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= vb[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.out_alpha     <= ml.alpha;
      result.hue_undefined <= ml.undef;
      if (~ml.op[1]) begin
        result.out_first  <= ml.f1;
        result.out_second <= ml.f2;
        result.out_third  <= ml.f3;
      end else begin
        result.out_first  <= {1'b0, (sr[CH_BITS] ? FULL_SCALE : sr[CH_BITS-1:0])};
        result.out_second <= sg[CH_BITS] ? FULL_SCALE : sg[CH_BITS-1:0];
        result.out_third  <= sb[CH_BITS] ? FULL_SCALE : sb[CH_BITS-1:0];
      end
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the color space converter against a bit-exact model of its
// fixed-point arithmetic, with random valid/ready pacing on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import rhh_pkg::*;

  localparam longint FS = 4095;
  localparam longint HFULL = 5760;
  localparam longint HSEC = 960;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [12:0] first;
    logic [11:0] second;
    logic [11:0] third;
    logic [11:0] alpha;
    logic        undef;
  } pix_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   failed = 1'b0;
  int   cycles = 0;
  int   hold_off = 0;
  bit   hold_req = 1'b0;
  bit   hold_ack = 1'b0;
  bit   stall_on = 1'b1;
  pix_res_t pending_pixels[$];

  rhh_in_if  pixel ();
  rhh_out_if result ();

  rgb_hsv_hsl_converter_core DUT (.clk(clk), .rst(rst), .pixel(pixel), .result(result));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint clamp_ch(longint v);
    return v > FS ? FS : v;
  endfunction

  function automatic longint rdiv(longint num, longint den);
    if (den == 0) return 0;
    return (num + den / 2) / den;
  endfunction

  function automatic longint sector_hue(longint base, longint p, longint q, longint c);
    longint h;
    if (p >= q) h = base + rdiv((p - q) * HSEC, c);
    else h = base - rdiv((q - p) * HSEC, c);
    if (h < 0) h += HFULL;
    if (h >= HFULL) h -= HFULL;
    return h;
  endfunction

  // expected converter output for one pixel
  function automatic pix_res_t convert_pixel(op_t op, logic [12:0] a, logic [11:0] s_in,
                                             logic [11:0] t_in, logic [11:0] alpha);
    pix_res_t res;
    longint r, g, b, mx, mn, c, h, s, t, sum, den, m, x, f, sec, two_l, span;
    int ch;
    res.alpha = alpha;
    if (op == OP_RGB2HSV || op == OP_RGB2HSL) begin
      r = clamp_ch(longint'(a)); g = longint'(s_in); b = longint'(t_in);
      ch = (r > g) ? 0 : 1;
      mx = (ch == 0) ? r : g;
      if (b > mx) begin ch = 2; mx = b; end
      mn = r < g ? r : g;
      if (b < mn) mn = b;
      c = mx - mn;
      if (c == 0) begin
        h = 0; s = 0; res.undef = 1'b1;
      end else begin
        if (ch == 0) h = sector_hue(0, g, b, c);
        else if (ch == 1) h = sector_hue(2 * HSEC, b, r, c);
        else h = sector_hue(4 * HSEC, r, g, c);
        if (op == OP_RGB2HSL) begin
          sum = mx + mn;
          den = sum <= FS ? sum : 2 * FS - sum;
          s = rdiv(c * FS, den);
        end else s = rdiv(c * FS, mx);
        res.undef = 1'b0;
      end
      t = (op == OP_RGB2HSL) ? (mx + mn + 1) >>> 1 : mx;
      res.first = 13'(h);
      res.second = 12'(clamp_ch(s));
      res.third = 12'(clamp_ch(t));
    end else begin
      h = longint'(a); s = longint'(s_in); t = longint'(t_in);
      if (h >= HFULL) h -= HFULL;
      if (op == OP_HSL2RGB) begin
        two_l = 2 * t;
        span = two_l <= FS ? two_l : 2 * FS - two_l;
        c = rdiv(span * s, FS);
        m = (two_l - c + 1) >>> 1;
      end else begin
        c = rdiv(t * s, FS);
        m = t - c;
      end
      sec = h / HSEC;
      f = h % HSEC;
      if (sec % 2 == 1) f = HSEC - f;
      x = rdiv(c * f, HSEC);
      case (sec)
        0: begin r = c; g = x; b = 0; end
        1: begin r = x; g = c; b = 0; end
        2: begin r = 0; g = c; b = x; end
        3: begin r = 0; g = x; b = c; end
        4: begin r = x; g = 0; b = c; end
        default: begin r = c; g = 0; b = x; end
      endcase
      res.first = 13'(clamp_ch(r + m));
      res.second = 12'(clamp_ch(g + m));
      res.third = 12'(clamp_ch(b + m));
      res.undef = 1'b0;
    end
    return res;
  endfunction

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_off <= HOLD_CYCLES - 1;
      result.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      result.ready <= 1'b0;
    end else if (!stall_on) result.ready <= 1'b1;
    else result.ready <= ($urandom_range(0, 3) != 0);
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    pix_res_t exp_px;
    if (!rst && result.valid && result.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result beat");
        failed <= 1'b1;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (result.out_first !== exp_px.first) begin
          $error("out_first exp %0d got %0d", exp_px.first, result.out_first);
          failed <= 1'b1;
        end
        if (result.out_second !== exp_px.second) begin
          $error("out_second exp %0d got %0d", exp_px.second, result.out_second);
          failed <= 1'b1;
        end
        if (result.out_third !== exp_px.third) begin
          $error("out_third exp %0d got %0d", exp_px.third, result.out_third);
          failed <= 1'b1;
        end
        if (result.out_alpha !== exp_px.alpha) begin
          $error("out_alpha exp %0d got %0d", exp_px.alpha, result.out_alpha);
          failed <= 1'b1;
        end
        if (result.hue_undefined !== exp_px.undef) begin
          $error("hue_undefined exp %0d got %0d", exp_px.undef, result.hue_undefined);
          failed <= 1'b1;
        end
      end
    end
  end

  // send one pixel beat; valid stays high until the sender idles
  task automatic send_pixel(op_t op, logic [12:0] a, logic [11:0] s, logic [11:0] t,
                            logic [11:0] alpha);
    pixel.valid <= 1'b1;
    pixel.operation <= op;
    pixel.in_first <= a;
    pixel.in_second <= s;
    pixel.in_third <= t;
    pixel.in_alpha <= alpha;
    do @(posedge clk); while (!pixel.ready);
    pending_pixels.push_back(convert_pixel(op, a, s, t, alpha));
  endtask

  task automatic idle_cycles(int n);
    pixel.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    pixel.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic logic [12:0] rand_first(op_t op);
    if (op == OP_RGB2HSV || op == OP_RGB2HSL) begin
      if ($urandom_range(0, 7) == 0) return 13'($urandom_range(4096, 8191));
      return 13'($urandom_range(0, 4095));
    end
    if ($urandom_range(0, 7) == 0) return 13'($urandom_range(5760, 8191));
    return 13'($urandom_range(0, 5759));
  endfunction

  // directed corner pixels
  task automatic test_corners();
    send_pixel(OP_RGB2HSV, 13'd0, 12'd0, 12'd0, 12'd0);
    send_pixel(OP_RGB2HSV, 13'd4095, 12'd4095, 12'd4095, 12'd4095);
    send_pixel(OP_RGB2HSL, 13'd2000, 12'd2000, 12'd2000, 12'd7);
    send_pixel(OP_RGB2HSV, 13'd4095, 12'd0, 12'd100, 12'd1);
    send_pixel(OP_RGB2HSV, 13'd4000, 12'd4000, 12'd10, 12'd2);
    send_pixel(OP_RGB2HSV, 13'd10, 12'd4000, 12'd4000, 12'd3);
    send_pixel(OP_RGB2HSL, 13'd4000, 12'd10, 12'd4000, 12'd4);
    send_pixel(OP_RGB2HSL, 13'd8191, 12'd0, 12'd0, 12'd5);
    send_pixel(OP_RGB2HSL, 13'd4095, 12'd4094, 12'd0, 12'd6);
    send_pixel(OP_RGB2HSL, 13'd1, 12'd0, 12'd0, 12'd8);
    send_pixel(OP_HSV2RGB, 13'd0, 12'd4095, 12'd4095, 12'd9);
    send_pixel(OP_HSV2RGB, 13'd5759, 12'd4095, 12'd4095, 12'd10);
    send_pixel(OP_HSV2RGB, 13'd8191, 12'd4095, 12'd4095, 12'd11);
    send_pixel(OP_HSV2RGB, 13'd960, 12'd0, 12'd2048, 12'd12);
    send_pixel(OP_HSL2RGB, 13'd1920, 12'd4095, 12'd2048, 12'd13);
    send_pixel(OP_HSL2RGB, 13'd2880, 12'd4095, 12'd4095, 12'd14);
    send_pixel(OP_HSL2RGB, 13'd3840, 12'd4095, 12'd0, 12'd15);
    send_pixel(OP_HSL2RGB, 13'd4800, 12'd2000, 12'd3000, 12'd4095);
    send_pixel(OP_HSL2RGB, 13'd5760, 12'd1234, 12'd1000, 12'd2730);
    drain();
  endtask

  // random pixels in bursts with gaps
  task automatic test_random(int count);
    int sent;
    int burst;
    op_t op;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        op = op_t'($urandom_range(0, 3));
        send_pixel(op, rand_first(op), 12'($urandom), 12'($urandom), 12'($urandom));
        sent++;
      end
      if ($urandom_range(0, 1)) idle_cycles($urandom_range(1, 12));
    end
  endtask

  // receiver holds off while the sender keeps offering pixels
  task automatic test_backpressure();
    op_t op;
    hold_req <= ~hold_req;
    for (int i = 0; i < 40; i++) begin
      op = op_t'($urandom_range(0, 3));
      send_pixel(op, rand_first(op), 12'($urandom), 12'($urandom), 12'($urandom));
    end
    drain();
  endtask

  // full rate on both sides
  task automatic test_full_rate();
    op_t op;
    stall_on = 1'b0;
    for (int i = 0; i < 100; i++) begin
      op = op_t'($urandom_range(0, 3));
      send_pixel(op, rand_first(op), 12'($urandom), 12'($urandom), 12'($urandom));
    end
    drain();
    stall_on = 1'b1;
  endtask

  initial begin
    pixel.valid = 1'b0;
    pixel.operation = OP_RGB2HSV;
    pixel.in_first = '0;
    pixel.in_second = '0;
    pixel.in_third = '0;
    pixel.in_alpha = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_random(280);
    drain();
    test_backpressure();
    test_full_rate();
    test_random(280);
    drain();
    idle_cycles(40);
    if (!failed && pending_pixels.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

### files.f
rtl/core/rhh_pkg.sv
rtl/core/rhh_stream_if.sv
rtl/core/rhh_div.sv
rtl/core/rgb_hsv_hsl_converter_core.sv
tb/tb_top.sv
